[src/vector2d_alu_core_assert.svh]
// Assertion macros used by the vector ALU core.
`ifndef VECTOR2D_ALU_CORE_ASSERT_SVH
`define VECTOR2D_ALU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define V2A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define V2A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/v2a_pkg.sv]
`timescale 1ns / 1ps

package v2a_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SQ_W       = 2 * WORD_BITS;
  localparam int SQ_STAGES  = WORD_BITS;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int V_W        = 2 * WORD_BITS + 2;
  localparam int MAG_W      = 2 * WORD_BITS + 1;

  localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [MAG_W-1:0]     HALF    = MAG_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6
  } op_t;

  typedef struct packed {
    logic [SQ_W-1:0]      prod;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] amag;
    logic                 aneg;
  } lane_t;

  typedef struct packed {
    op_t                  op;
    logic [WORD_BITS-1:0] rx;
    logic [WORD_BITS-1:0] ry;
    logic                 sat;
    logic [WORD_BITS-1:0] axm;
    logic [WORD_BITS-1:0] aym;
    logic                 axn;
    logic                 ayn;
  } side_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 sat;
  } rs_t;

  function automatic rs_t round_sat(logic [MAG_W-1:0] mag, logic neg, logic rnd);
    logic [MAG_W-1:0] r;
    logic [MAG_W-1:0] lim;
    rs_t o;
    r = rnd ? ((mag + HALF) >> FRAC_BITS) : mag;
    lim = neg ? (MAG_W'(MAX_POS) + MAG_W'(1)) : MAG_W'(MAX_POS);
    o.sat = (r > lim);
    if (o.sat) begin
      r = lim;
    end
    o.val = neg ? (~r[WORD_BITS-1:0] + 1'b1) : r[WORD_BITS-1:0];
    return o;
  endfunction

endpackage

[src/v2a_lane.sv]
`timescale 1ns / 1ps

module v2a_lane (
  input  logic                                clk,
  input  logic                                en,
  input  v2a_pkg::op_t                        op,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] a,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] b_own,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] b_other,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] scalar,
  output v2a_pkg::lane_t                      res
);

  logic signed [v2a_pkg::WORD_BITS-1:0] mul_b;
  logic signed [v2a_pkg::SQ_W-1:0]      prod;
  logic signed [v2a_pkg::WORD_BITS:0]   sum;
  v2a_pkg::lane_t                       lane_nxt;
  v2a_pkg::lane_t                       lane_r;

  always_comb begin
    case (op)
      v2a_pkg::OP_SCALE: mul_b = scalar;
      v2a_pkg::OP_DOT:   mul_b = b_own;
      v2a_pkg::OP_CROSS: mul_b = b_other;
      default:           mul_b = a;
    endcase
    prod = a * mul_b;
    if (op == v2a_pkg::OP_SUB) begin
      sum = (v2a_pkg::WORD_BITS+1)'(a) - (v2a_pkg::WORD_BITS+1)'(b_own);
    end else begin
      sum = (v2a_pkg::WORD_BITS+1)'(a) + (v2a_pkg::WORD_BITS+1)'(b_own);
    end
    lane_nxt.prod = prod;
    lane_nxt.sum  = sum;
    lane_nxt.amag = a[v2a_pkg::WORD_BITS-1] ? v2a_pkg::WORD_BITS'(-a) : a;
    lane_nxt.aneg = a[v2a_pkg::WORD_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign res = lane_r;

endmodule

[src/v2a_merge.sv]
`timescale 1ns / 1ps

module v2a_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  v2a_pkg::op_t                op,
  input  v2a_pkg::lane_t              lx,
  input  v2a_pkg::lane_t              ly,
  output logic                        out_vld,
  output v2a_pkg::side_t              out_side,
  output logic [v2a_pkg::SQ_W-1:0]    out_sumsq
);

  logic signed [v2a_pkg::SQ_W-1:0] px;
  logic signed [v2a_pkg::SQ_W-1:0] py;
  logic signed [v2a_pkg::V_W-1:0]  vx_nxt;
  logic signed [v2a_pkg::V_W-1:0]  vy_nxt;
  logic                            rnd_nxt;
  v2a_pkg::side_t                  side_a_nxt;

  logic                            a_vld_r;
  logic signed [v2a_pkg::V_W-1:0]  a_vx_r;
  logic signed [v2a_pkg::V_W-1:0]  a_vy_r;
  logic                            a_rnd_r;
  v2a_pkg::side_t                  a_side_r;
  logic [v2a_pkg::SQ_W-1:0]        a_sumsq_r;

  logic                            b_vld_r;
  logic                            b_negx_r;
  logic                            b_negy_r;
  logic [v2a_pkg::MAG_W-1:0]       b_magx_r;
  logic [v2a_pkg::MAG_W-1:0]       b_magy_r;
  logic                            b_rnd_r;
  v2a_pkg::side_t                  b_side_r;
  logic [v2a_pkg::SQ_W-1:0]        b_sumsq_r;

  v2a_pkg::rs_t                    rsx;
  v2a_pkg::rs_t                    rsy;
  v2a_pkg::side_t                  side_c_nxt;
  logic                            c_vld_r;
  v2a_pkg::side_t                  c_side_r;
  logic [v2a_pkg::SQ_W-1:0]        c_sumsq_r;

  always_comb begin
    px = $signed(lx.prod);
    py = $signed(ly.prod);
    vx_nxt = '0;
    vy_nxt = '0;
    rnd_nxt = 1'b0;
    case (op)
      v2a_pkg::OP_ADD, v2a_pkg::OP_SUB: begin
        vx_nxt = v2a_pkg::V_W'($signed(lx.sum));
        vy_nxt = v2a_pkg::V_W'($signed(ly.sum));
      end
      v2a_pkg::OP_SCALE: begin
        vx_nxt = v2a_pkg::V_W'(px);
        vy_nxt = v2a_pkg::V_W'(py);
        rnd_nxt = 1'b1;
      end
      v2a_pkg::OP_DOT: begin
        vx_nxt = v2a_pkg::V_W'(px) + v2a_pkg::V_W'(py);
        rnd_nxt = 1'b1;
      end
      v2a_pkg::OP_CROSS: begin
        vx_nxt = v2a_pkg::V_W'(px) - v2a_pkg::V_W'(py);
        rnd_nxt = 1'b1;
      end
      default: ;
    endcase
    side_a_nxt.op  = op;
    side_a_nxt.rx  = '0;
    side_a_nxt.ry  = '0;
    side_a_nxt.sat = 1'b0;
    side_a_nxt.axm = lx.amag;
    side_a_nxt.aym = ly.amag;
    side_a_nxt.axn = lx.aneg;
    side_a_nxt.ayn = ly.aneg;
  end

  always_comb begin
    rsx = v2a_pkg::round_sat(b_magx_r, b_negx_r, b_rnd_r);
    rsy = v2a_pkg::round_sat(b_magy_r, b_negy_r, b_rnd_r);
    side_c_nxt     = b_side_r;
    side_c_nxt.rx  = rsx.val;
    side_c_nxt.ry  = rsy.val;
    side_c_nxt.sat = rsx.sat | rsy.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vx_r    <= vx_nxt;
      a_vy_r    <= vy_nxt;
      a_rnd_r   <= rnd_nxt;
      a_side_r  <= side_a_nxt;
      a_sumsq_r <= lx.prod + ly.prod;
      b_negx_r  <= a_vx_r[v2a_pkg::V_W-1];
      b_negy_r  <= a_vy_r[v2a_pkg::V_W-1];
      b_magx_r  <= v2a_pkg::MAG_W'(a_vx_r[v2a_pkg::V_W-1] ? -a_vx_r : a_vx_r);
      b_magy_r  <= v2a_pkg::MAG_W'(a_vy_r[v2a_pkg::V_W-1] ? -a_vy_r : a_vy_r);
      b_rnd_r   <= a_rnd_r;
      b_side_r  <= a_side_r;
      b_sumsq_r <= a_sumsq_r;
      c_side_r  <= side_c_nxt;
      c_sumsq_r <= b_sumsq_r;
    end
  end

  assign out_vld   = c_vld_r;
  assign out_side  = c_side_r;
  assign out_sumsq = c_sumsq_r;

endmodule

[src/v2a_isqrt.sv]
`timescale 1ns / 1ps

module v2a_isqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [v2a_pkg::SQ_W-1:0]         in_num,
  input  v2a_pkg::side_t                   in_side,
  output logic                             out_vld,
  output logic [v2a_pkg::WORD_BITS-1:0]    out_len,
  output v2a_pkg::side_t                   out_side
);

  logic                     vld_r  [v2a_pkg::SQ_STAGES];
  logic [v2a_pkg::SQ_W-1:0] num_r  [v2a_pkg::SQ_STAGES];
  logic [v2a_pkg::SQ_W-1:0] res_r  [v2a_pkg::SQ_STAGES];
  v2a_pkg::side_t           side_r [v2a_pkg::SQ_STAGES];

  for (genvar i = 0; i < v2a_pkg::SQ_STAGES; i++) begin : g_stage
    localparam logic [v2a_pkg::SQ_W-1:0] BIT =
      v2a_pkg::SQ_W'(1) << (v2a_pkg::SQ_W - 2 - 2 * i);
    logic                     vld_in;
    logic [v2a_pkg::SQ_W-1:0] num_in;
    logic [v2a_pkg::SQ_W-1:0] res_in;
    v2a_pkg::side_t           side_in;
    logic [v2a_pkg::SQ_W:0]   t;
    logic [v2a_pkg::SQ_W-1:0] num_nxt;
    logic [v2a_pkg::SQ_W-1:0] res_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign num_in  = in_num;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign num_in  = num_r[i-1];
      assign res_in  = res_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      t = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, num_in} >= t) begin
        num_nxt = num_in - t[v2a_pkg::SQ_W-1:0];
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        num_nxt = num_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i]  <= num_nxt;
        res_r[i]  <= res_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[v2a_pkg::SQ_STAGES-1];
  assign out_len  = res_r[v2a_pkg::SQ_STAGES-1][v2a_pkg::WORD_BITS-1:0];
  assign out_side = side_r[v2a_pkg::SQ_STAGES-1];

endmodule

[src/v2a_div.sv]
`timescale 1ns / 1ps

module v2a_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [v2a_pkg::WORD_BITS-1:0] in_a,
  input  logic [v2a_pkg::WORD_BITS-1:0] in_d,
  output logic [v2a_pkg::FRAC_BITS:0]   out_q
);

  logic [v2a_pkg::WORD_BITS-1:0] rem_r [v2a_pkg::DIV_STAGES];
  logic [v2a_pkg::WORD_BITS-1:0] d_r   [v2a_pkg::DIV_STAGES];
  logic [v2a_pkg::FRAC_BITS:0]   q_r   [v2a_pkg::DIV_STAGES];

  for (genvar j = 0; j < v2a_pkg::DIV_STAGES; j++) begin : g_stage
    logic [v2a_pkg::WORD_BITS-1:0] rem_in;
    logic [v2a_pkg::WORD_BITS-1:0] d_in;
    logic [v2a_pkg::FRAC_BITS:0]   q_in;
    logic                          bit_in;
    logic [v2a_pkg::WORD_BITS:0]   r2;
    logic [v2a_pkg::WORD_BITS:0]   diff;
    logic [v2a_pkg::WORD_BITS-1:0] rem_nxt;
    logic [v2a_pkg::FRAC_BITS:0]   q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, in_a[v2a_pkg::WORD_BITS-1:1]};
      assign bit_in = in_a[0];
      assign d_in   = in_d;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign bit_in = 1'b0;
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
    end

    always_comb begin
      r2   = {rem_in, bit_in};
      diff = r2 - {1'b0, d_in};
      if (r2 >= {1'b0, d_in}) begin
        rem_nxt = diff[v2a_pkg::WORD_BITS-1:0];
        q_nxt   = {q_in[v2a_pkg::FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_nxt = r2[v2a_pkg::WORD_BITS-1:0];
        q_nxt   = {q_in[v2a_pkg::FRAC_BITS-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        d_r[j]   <= d_in;
        q_r[j]   <= q_nxt;
      end
    end
  end

  assign out_q = q_r[v2a_pkg::DIV_STAGES-1];

endmodule

[src/vector2d_alu_core.sv]
// vector2d_alu_core: fixed-point 2D vector ALU, signed Q16.16 throughout.
// Input channel: in_valid/in_ready carry one word of operation, vectors
// (in_ax, in_ay), (in_bx, in_by) and in_scalar. Output channel:
// out_valid/out_ready carry out_rx, out_ry and out_saturated.
// Operations: add, sub, scale, dot, cross, length, normalize; scalar
// results land in out_rx with out_ry zero; code 7 returns zeros.
// Pipeline: 54 register stages (1 multiply, 3 merge/round, 32 square-root,
// 17 divide, 1 output). Every operation takes the same path.
// Throughput: one word per cycle while not stalled; the x and y lanes, the
// square-root pipeline and both divider lanes each take a word every cycle.
// Backpressure: when the output word is not taken the whole pipeline
// holds and in_ready drops; it rises again in the cycle the word leaves.
// Bubbles from idle input cycles travel down the pipeline as empty slots.
// Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
`timescale 1ns / 1ps
`include "vector2d_alu_core_assert.svh"

module vector2d_alu_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_operation,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] in_ax,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] in_ay,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] in_bx,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] in_by,
  input  logic signed [v2a_pkg::WORD_BITS-1:0] in_scalar,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [v2a_pkg::WORD_BITS-1:0] out_rx,
  output logic signed [v2a_pkg::WORD_BITS-1:0] out_ry,
  output logic                                 out_saturated
);

  localparam logic [v2a_pkg::WORD_BITS-1:0] NORM_ONE =
    v2a_pkg::WORD_BITS'(1) << v2a_pkg::FRAC_BITS;
  localparam logic [v2a_pkg::WORD_BITS-1:0] NORM_MONE = ~NORM_ONE + 1'b1;

  logic                          en;
  v2a_pkg::op_t                  op_in;
  logic                          s1_vld_r;
  v2a_pkg::op_t                  s1_op_r;
  v2a_pkg::lane_t                lane_x;
  v2a_pkg::lane_t                lane_y;

  logic                          m_vld;
  v2a_pkg::side_t                m_side;
  logic [v2a_pkg::SQ_W-1:0]      m_sumsq;

  logic                          sq_vld;
  logic [v2a_pkg::WORD_BITS-1:0] sq_len;
  v2a_pkg::side_t                sq_side;

  logic [v2a_pkg::FRAC_BITS:0]   qx;
  logic [v2a_pkg::FRAC_BITS:0]   qy;

  logic                          dly_vld_r  [v2a_pkg::DIV_STAGES];
  v2a_pkg::side_t                dly_side_r [v2a_pkg::DIV_STAGES];
  logic [v2a_pkg::WORD_BITS-1:0] dly_len_r  [v2a_pkg::DIV_STAGES];

  logic                          fin_vld;
  v2a_pkg::side_t                fin_side;
  logic [v2a_pkg::WORD_BITS-1:0] fin_len;
  logic [v2a_pkg::WORD_BITS-1:0] qx_ext;
  logic [v2a_pkg::WORD_BITS-1:0] qy_ext;
  logic [v2a_pkg::WORD_BITS-1:0] rx_nxt;
  logic [v2a_pkg::WORD_BITS-1:0] ry_nxt;
  logic                          sat_nxt;

  logic                          out_valid_r;
  logic [v2a_pkg::WORD_BITS-1:0] out_rx_r;
  logic [v2a_pkg::WORD_BITS-1:0] out_ry_r;
  logic                          out_sat_r;
  v2a_pkg::op_t                  out_op_r;

  logic                          out_norm;
  logic                          out_scalar;
  logic                          norm_in_range;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign op_in    = v2a_pkg::op_t'(in_operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= op_in;
    end
  end

  v2a_lane u_lane_x (
    .clk     (clk),
    .en      (en),
    .op      (op_in),
    .a       (in_ax),
    .b_own   (in_bx),
    .b_other (in_by),
    .scalar  (in_scalar),
    .res     (lane_x)
  );

  v2a_lane u_lane_y (
    .clk     (clk),
    .en      (en),
    .op      (op_in),
    .a       (in_ay),
    .b_own   (in_by),
    .b_other (in_bx),
    .scalar  (in_scalar),
    .res     (lane_y)
  );

  v2a_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s1_vld_r),
    .op        (s1_op_r),
    .lx        (lane_x),
    .ly        (lane_y),
    .out_vld   (m_vld),
    .out_side  (m_side),
    .out_sumsq (m_sumsq)
  );

  v2a_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m_vld),
    .in_num   (m_sumsq),
    .in_side  (m_side),
    .out_vld  (sq_vld),
    .out_len  (sq_len),
    .out_side (sq_side)
  );

  v2a_div u_div_x (
    .clk   (clk),
    .en    (en),
    .in_a  (sq_side.axm),
    .in_d  (sq_len),
    .out_q (qx)
  );

  v2a_div u_div_y (
    .clk   (clk),
    .en    (en),
    .in_a  (sq_side.aym),
    .in_d  (sq_len),
    .out_q (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < v2a_pkg::DIV_STAGES; k++) begin
        dly_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      dly_vld_r[0] <= sq_vld;
      for (int k = 1; k < v2a_pkg::DIV_STAGES; k++) begin
        dly_vld_r[k] <= dly_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_side_r[0] <= sq_side;
      dly_len_r[0]  <= sq_len;
      for (int k = 1; k < v2a_pkg::DIV_STAGES; k++) begin
        dly_side_r[k] <= dly_side_r[k-1];
        dly_len_r[k]  <= dly_len_r[k-1];
      end
    end
  end

  assign fin_vld = dly_vld_r[v2a_pkg::DIV_STAGES-1];

  always_comb begin
    fin_side = dly_side_r[v2a_pkg::DIV_STAGES-1];
    fin_len  = dly_len_r[v2a_pkg::DIV_STAGES-1];
    qx_ext   = v2a_pkg::WORD_BITS'(qx);
    qy_ext   = v2a_pkg::WORD_BITS'(qy);
    rx_nxt   = fin_side.rx;
    ry_nxt   = fin_side.ry;
    sat_nxt  = fin_side.sat;
    case (fin_side.op)
      v2a_pkg::OP_LEN: begin
        ry_nxt = '0;
        if (fin_len > v2a_pkg::MAX_POS) begin
          rx_nxt  = v2a_pkg::MAX_POS;
          sat_nxt = 1'b1;
        end else begin
          rx_nxt  = fin_len;
          sat_nxt = 1'b0;
        end
      end
      v2a_pkg::OP_NORM: begin
        sat_nxt = 1'b0;
        if (fin_len == '0) begin
          rx_nxt = '0;
          ry_nxt = '0;
        end else begin
          rx_nxt = fin_side.axn ? (~qx_ext + 1'b1) : qx_ext;
          ry_nxt = fin_side.ayn ? (~qy_ext + 1'b1) : qy_ext;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rx_r  <= rx_nxt;
      out_ry_r  <= ry_nxt;
      out_sat_r <= sat_nxt;
      out_op_r  <= fin_side.op;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rx        = out_rx_r;
  assign out_ry        = out_ry_r;
  assign out_saturated = out_sat_r;

  assign out_norm      = out_valid_r && (out_op_r == v2a_pkg::OP_NORM);
  assign out_scalar    = out_valid_r &&
                         (out_op_r inside {v2a_pkg::OP_DOT, v2a_pkg::OP_CROSS, v2a_pkg::OP_LEN});
  assign norm_in_range = ($signed(out_rx_r) <= $signed(NORM_ONE)) &&
                         ($signed(out_rx_r) >= $signed(NORM_MONE));

  `V2A_ASSERT_NXT(a_drain, (fin_vld && en), out_valid_r, "word lost at output")
  `V2A_ASSERT_IMP(a_norm_nosat, out_norm, !out_sat_r, "normalize saturated")
  `V2A_ASSERT_IMP(a_norm_range, out_norm, norm_in_range, "normalize out of unit range")
  `V2A_ASSERT_IMP(a_scalar_ry, out_scalar, (out_ry_r == '0), "scalar result with nonzero y")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    logic        sat;
  } vec_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic signed [31:0] in_ax, in_ay, in_bx, in_by, in_scalar;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_rx, out_ry;
  logic        out_saturated;

  vec_res_t result_q[$];
  int          fail_cnt;
  int          send_idle;
  int          recv_idle;
  int          hold_left;
  logic        hold_req;

  vector2d_alu_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_ax(in_ax), .in_ay(in_ay), .in_bx(in_bx), .in_by(in_by), .in_scalar(in_scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rx(out_rx), .out_ry(out_ry), .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clamp_word(input logic neg, input logic [127:0] mag,
                                             inout logic sat);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = mag;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? (~m[31:0] + 32'd1) : m[31:0];
  endfunction

  function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [127:0] round_mag(input logic signed [127:0] v);
    return (abs_wide(v) + 128'h8000) >> v2a_pkg::FRAC_BITS;
  endfunction

  function automatic logic [127:0] isqrt_wide(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic vec_res_t predict_vector(input logic [2:0] op,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] sc);
    logic signed [127:0] wax, way, wbx, wby, wsc, v;
    logic [127:0] len;
    logic sat;
    vec_res_t r;
    wax = ax; way = ay; wbx = bx; wby = by; wsc = sc;
    sat = 1'b0;
    r.rx = '0;
    r.ry = '0;
    case (op)
      v2a_pkg::OP_ADD: begin
        v = wax + wbx; r.rx = clamp_word(v < 0, abs_wide(v), sat);
        v = way + wby; r.ry = clamp_word(v < 0, abs_wide(v), sat);
      end
      v2a_pkg::OP_SUB: begin
        v = wax - wbx; r.rx = clamp_word(v < 0, abs_wide(v), sat);
        v = way - wby; r.ry = clamp_word(v < 0, abs_wide(v), sat);
      end
      v2a_pkg::OP_SCALE: begin
        v = wax * wsc; r.rx = clamp_word(v < 0, round_mag(v), sat);
        v = way * wsc; r.ry = clamp_word(v < 0, round_mag(v), sat);
      end
      v2a_pkg::OP_DOT: begin
        v = wax * wbx + way * wby; r.rx = clamp_word(v < 0, round_mag(v), sat);
      end
      v2a_pkg::OP_CROSS: begin
        v = wax * wby - way * wbx; r.rx = clamp_word(v < 0, round_mag(v), sat);
      end
      v2a_pkg::OP_LEN: begin
        len = isqrt_wide(abs_wide(wax) * abs_wide(wax) + abs_wide(way) * abs_wide(way));
        r.rx = clamp_word(1'b0, len, sat);
      end
      v2a_pkg::OP_NORM: begin
        len = isqrt_wide(abs_wide(wax) * abs_wide(wax) + abs_wide(way) * abs_wide(way));
        if (len != 0) begin
          r.rx = clamp_word(ax < 0, (abs_wide(wax) << v2a_pkg::FRAC_BITS) / len, sat);
          r.ry = clamp_word(ay < 0, (abs_wide(way) << v2a_pkg::FRAC_BITS) / len, sat);
        end
      end
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] bx, input logic [31:0] by,
                           input logic [31:0] sc);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation = op;
    in_ax = ax; in_ay = ay; in_bx = bx; in_by = by; in_scalar = sc;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    result_q.push_back(predict_vector(op, ax, ay, bx, by, sc));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 32'h3_ffff));
      3: return -32'($urandom_range(0, 32'h3_ffff));
      4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    return ($urandom_range(39) == 0) ? OP_UNUSED : 3'($urandom_range(v2a_pkg::OP_NORM));
  endfunction

  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_word(v2a_pkg::OP_ADD, mx, mn, mx, mn, 0);
    send_word(v2a_pkg::OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_0001, 0);
    send_word(v2a_pkg::OP_SUB, mn, mx, 32'h0000_0001, 32'hffff_ffff, 0);
    send_word(v2a_pkg::OP_SUB, mn, mn, mn, mn, 0);
    send_word(v2a_pkg::OP_SCALE, mx, mn, 0, 0, mx);
    send_word(v2a_pkg::OP_SCALE, mn, mn, 0, 0, mn);
    send_word(v2a_pkg::OP_SCALE, 32'h0000_0001, 32'hffff_ffff, 0, 0, 32'h0000_8000);
    send_word(v2a_pkg::OP_SCALE, 32'h0003_0000, 32'hfffe_8000, 0, 0, 32'h0001_8000);
    send_word(v2a_pkg::OP_DOT, mn, mn, mn, mn, 0);
    send_word(v2a_pkg::OP_DOT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000, 0);
    send_word(v2a_pkg::OP_CROSS, mn, mx, mx, mn, 0);
    send_word(v2a_pkg::OP_CROSS, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_word(v2a_pkg::OP_LEN, mn, mn, 0, 0, 0);
    send_word(v2a_pkg::OP_LEN, 32'h0003_0000, 32'h0004_0000, 0, 0, 0);
    send_word(v2a_pkg::OP_LEN, 0, 0, 0, 0, 0);
    send_word(v2a_pkg::OP_NORM, 0, 0, 0, 0, 0);
    send_word(v2a_pkg::OP_NORM, mn, 0, 0, 0, 0);
    send_word(v2a_pkg::OP_NORM, mx, mn, 0, 0, 0);
    send_word(v2a_pkg::OP_NORM, 32'h0000_0001, 32'hffff_ffff, 0, 0, 0);
    send_word(OP_UNUSED, mx, mn, mx, mn, mx);
    send_word(OP_UNUSED, 0, 0, 0, 0, 0);
    wait_drain();
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_word(rand_op(), rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word());
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    repeat (150) send_word(rand_op(), rand_word(), rand_word(), rand_word(), rand_word(),
                           rand_word());
  endtask

  task automatic test_pause();
    test_random(40, 10, 10);
    wait_drain();
    test_random(40, 0, 0);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    vec_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result word rx=%h ry=%h", out_rx, out_ry);
        fail_cnt++;
      end else begin
        e = result_q.pop_front();
        if (out_rx !== e.rx) begin
          $error("rx: expected %h actual %h", e.rx, out_rx);
          fail_cnt++;
        end
        if (out_ry !== e.ry) begin
          $error("ry: expected %h actual %h", e.ry, out_ry);
          fail_cnt++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %b actual %b", e.sat, out_saturated);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    fail_cnt = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    hold_req = 1'b0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_ax = '0; in_ay = '0; in_bx = '0; in_by = '0; in_scalar = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(550, 14, 46);
    test_random(550, 46, 14);
    test_random(450, 0, 0);
    test_backpressure();
    test_pause();
    wait_drain();
    if (result_q.size() != 0) begin
      $error("%0d result words never arrived", result_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
